// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  localparam int unsigned OrderW = 5;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned StatW  = 3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_ZERO     = 3'd1;
  localparam logic [StatW-1:0] ST_TOO_BIG  = 3'd2;
  localparam logic [StatW-1:0] ST_NO_FIT   = 3'd3;
  localparam logic [StatW-1:0] ST_IGNORED  = 3'd4;

  // one granule entry of the block table
  typedef struct packed {
    logic              head;
    logic              free;
    logic [OrderW-1:0] order;
  } entry_t;

  typedef enum logic [9:0] {
    S_CLR      = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN_CHK = 10'b0000001000,
    S_SPLIT    = 10'b0000010000,
    S_FR_CHK   = 10'b0000100000,
    S_MG_RD    = 10'b0001000000,
    S_MG_CHK   = 10'b0010000000,
    S_FIN      = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

endpackage

// ===== rtl/bba_if.sv =====
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [SizeW-1:0] request_size;
  logic [AddrW-1:0] free_address;
  modport source (output valid, action, request_size, free_address, input ready);
  modport sink   (input valid, action, request_size, free_address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic [AddrW-1:0]  address;
  logic [OrderW-1:0] block_order;
  modport source (output valid, status, address, block_order, input ready);
  modport sink   (input valid, status, address, block_order, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OrderW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/buddy_block_allocator.sv =====
// Buddy allocator over a pool of 2^P bytes held as a table of 2^(MAX_ORDER-MIN_ORDER)
// granule entries in one RAM with one read port and one write port. Every table access
// goes through that RAM, so the time per item varies: allocate reads each block
// visited by the best-fit scan, which walks the whole pool, then writes one entry per
// split and marks the chosen block; free reads the block, then reads each buddy and
// merges until a buddy is busy or the pool is whole, and writes the result; a request
// refused on its fields alone does not touch the table and a free refused at the table
// check reads one entry. Each result then waits in S_DONE until the output register is
// free. After reset and after every pool order write the table is cleared, one entry
// per cycle, during which no request is taken; configuration writes are always taken.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_ORDER    = 16,
  parameter int unsigned MIN_ORDER    = 4,
  parameter int unsigned HEADER_BYTES = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  bba_cfg_if.sink   cfg_i,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  localparam int unsigned GW = MAX_ORDER - MIN_ORDER;

  logic          ram_we;
  logic [GW-1:0] ram_waddr;
  logic [GW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  bba_ctrl #(
    .MAX_ORDER    (MAX_ORDER),
    .MIN_ORDER    (MIN_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_data_i  (cfg_i.data),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .action_i    (req_i.action),
    .size_i      (req_i.request_size),
    .addr_i      (req_i.free_address),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .address_o   (rsp_o.address),
    .order_o     (rsp_o.block_order),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bba_ram #(
    .Width ($bits(entry_t)),
    .Depth (1 << GW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while previous one in progress");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |-> rsp_o.address == '0 && rsp_o.block_order == '0)
    else $error("error result carries nonzero fields");

  a_ok_order_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_OK |-> rsp_o.block_order >= OrderW'(MIN_ORDER))
    else $error("block order below granule");
`endif

endmodule

// ===== rtl/bba_ram.sv =====
module bba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_ctrl.sv =====
module bba_ctrl import bba_pkg::*; #(
  parameter int unsigned MAX_ORDER    = 16,
  parameter int unsigned MIN_ORDER    = 4,
  parameter int unsigned HEADER_BYTES = 2,
  localparam int unsigned GW = MAX_ORDER - MIN_ORDER
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [OrderW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [SizeW-1:0]  size_i,
  input  logic [AddrW-1:0]  addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [StatW-1:0]  status_o,
  output logic [AddrW-1:0]  address_o,
  output logic [OrderW-1:0] order_o,
  output logic              ram_we_o,
  output logic [GW-1:0]     ram_waddr_o,
  output entry_t            ram_wdata_o,
  output logic [GW-1:0]     ram_raddr_o,
  input  entry_t            ram_rdata_i
);

  localparam int unsigned CW       = GW + 1;
  localparam int unsigned Granules = 1 << GW;

  state_e            state_q, state_d;
  logic [OrderW-1:0] pool_q, pool_d;
  logic [CW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     g_q, g_d;
  logic [CW-1:0]     b_q, b_d;
  logic [GW-1:0]     best_q, best_d;
  logic [OrderW-1:0] best_o_q, best_o_d;
  logic              found_q, found_d;
  logic [OrderW-1:0] need_q, need_d;
  logic [OrderW-1:0] o_q, o_d;
  logic [StatW-1:0]  res_st_q, res_st_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic [OrderW-1:0] res_ord_q, res_ord_d;
  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  out_st_q, out_st_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic [OrderW-1:0] out_ord_q, out_ord_d;

  logic [OrderW-1:0] p;
  logic [CW-1:0]     total;
  logic [SizeW:0]    nb_m1;
  logic [OrderW-1:0] need_raw, need;
  logic [AddrW-1:0]  off;
  logic [AddrW-1:0]  off_g;
  logic [CW-1:0]     step, b, lo, hi;
  entry_t            e;

  function automatic logic [OrderW-1:0] eff_order(input logic [OrderW-1:0] v);
    logic [OrderW-1:0] r;
    r = v;
    if (r < OrderW'(4)) r = OrderW'(5);
    if (r < OrderW'(MIN_ORDER)) r = OrderW'(MIN_ORDER);
    if (r > OrderW'(MAX_ORDER)) r = OrderW'(MAX_ORDER);
    return r;
  endfunction

  assign p     = eff_order(pool_q);
  assign total = CW'(1) << (p - OrderW'(MIN_ORDER));
  assign e     = ram_rdata_i;

  // bit length of size + header - 1 gives the ceiling log2
  assign nb_m1 = (SizeW + 1)'(size_i) + (SizeW + 1)'(HEADER_BYTES) - (SizeW + 1)'(1);
  always_comb begin
    need_raw = '0;
    for (int i = 0; i <= SizeW; i++) begin
      if (nb_m1[i]) need_raw = OrderW'(i + 1);
    end
    need = (need_raw < OrderW'(MIN_ORDER)) ? OrderW'(MIN_ORDER) : need_raw;
  end

  assign off   = addr_i - AddrW'(HEADER_BYTES);
  assign off_g = off >> MIN_ORDER;

  always_comb begin
    state_d     = state_q;
    pool_d      = pool_q;
    clr_d       = clr_q;
    g_d         = g_q;
    b_d         = b_q;
    best_d      = best_q;
    best_o_d    = best_o_q;
    found_d     = found_q;
    need_d      = need_q;
    o_d         = o_q;
    res_st_d    = res_st_q;
    res_addr_d  = res_addr_q;
    res_ord_d   = res_ord_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_addr_d  = out_addr_q;
    out_ord_d   = out_ord_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = g_q[GW-1:0];
    ram_wdata_o = '0;
    ram_raddr_o = g_q[GW-1:0];
    in_ready_o  = 1'b0;
    step        = CW'(1);
    b           = '0;
    lo          = '0;
    hi          = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q[GW-1:0];
        if (clr_q == '0) begin
          ram_wdata_o = '{head: 1'b1, free: 1'b1, order: p};
        end
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(Granules - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = !cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          res_addr_d = '0;
          res_ord_d  = '0;
          res_st_d   = ST_IGNORED;
          state_d    = S_DONE;
          if (action_i == ACT_FREE) begin
            if (addr_i != '0 && addr_i >= AddrW'(HEADER_BYTES) &&
                off[MIN_ORDER-1:0] == '0 && 32'(off_g) < 32'(total)) begin
              g_d         = CW'(off_g);
              ram_raddr_o = off_g[GW-1:0];
              state_d     = S_FR_CHK;
            end
          end else if (size_i == '0) begin
            res_st_d = ST_ZERO;
          end else if (need > p) begin
            res_st_d = ST_TOO_BIG;
          end else begin
            need_d  = need;
            g_d     = '0;
            found_d = 1'b0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (g_q >= total) begin
          if (!found_q) begin
            res_st_d = ST_NO_FIT;
            state_d  = S_DONE;
          end else begin
            o_d     = best_o_q;
            state_d = S_SPLIT;
          end
        end else begin
          ram_raddr_o = g_q[GW-1:0];
          state_d     = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (e.head && e.free && e.order >= need_q && e.order <= p &&
            (!found_q || e.order < best_o_q)) begin
          found_d  = 1'b1;
          best_d   = g_q[GW-1:0];
          best_o_d = e.order;
        end
        // hop over a whole block, else creep one granule
        if (e.head && e.order >= OrderW'(MIN_ORDER) && e.order <= p) begin
          step = CW'(1) << (e.order - OrderW'(MIN_ORDER));
        end
        g_d     = g_q + step;
        state_d = S_SCAN_RD;
      end
      S_SPLIT: begin
        ram_we_o = 1'b1;
        if (o_q > need_q) begin
          o_d = o_q - OrderW'(1);
          b   = CW'(best_q) + (CW'(1) << (o_d - OrderW'(MIN_ORDER)));
          ram_we_o    = (b < CW'(Granules));
          ram_waddr_o = b[GW-1:0];
          ram_wdata_o = '{head: 1'b1, free: 1'b1, order: o_d};
        end else begin
          ram_waddr_o = best_q;
          ram_wdata_o = '{head: 1'b1, free: 1'b0, order: need_q};
          res_st_d    = ST_OK;
          res_addr_d  = AddrW'((32'(best_q) << MIN_ORDER) + 32'(HEADER_BYTES));
          res_ord_d   = need_q;
          state_d     = S_DONE;
        end
      end
      S_FR_CHK: begin
        if (!e.head || e.free || e.order < OrderW'(MIN_ORDER) || e.order > p) begin
          state_d = S_DONE;
        end else begin
          o_d     = e.order;
          state_d = (e.order < p) ? S_MG_RD : S_FIN;
        end
      end
      S_MG_RD: begin
        b = g_q ^ (CW'(1) << (o_q - OrderW'(MIN_ORDER)));
        if (b >= total) begin
          state_d = S_FIN;
        end else begin
          b_d         = b;
          ram_raddr_o = b[GW-1:0];
          state_d     = S_MG_CHK;
        end
      end
      S_MG_CHK: begin
        if (e.head && e.free && e.order == o_q) begin
          lo = (g_q < b_q) ? g_q : b_q;
          hi = (g_q < b_q) ? b_q : g_q;
          // drop the upper half from the table
          ram_we_o    = 1'b1;
          ram_waddr_o = hi[GW-1:0];
          ram_wdata_o = '0;
          g_d     = lo;
          o_d     = o_q + OrderW'(1);
          state_d = (o_d < p) ? S_MG_RD : S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = g_q[GW-1:0];
        ram_wdata_o = '{head: 1'b1, free: 1'b1, order: o_q};
        res_st_d    = ST_OK;
        res_addr_d  = AddrW'(32'(g_q) << MIN_ORDER);
        res_ord_d   = o_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_addr_d  = res_addr_q;
          out_ord_d   = res_ord_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase

    if (cfg_valid_i) begin
      pool_d  = cfg_data_i;
      clr_d   = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      pool_q      <= OrderW'(16);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q        <= g_d;
    b_q        <= b_d;
    best_q     <= best_d;
    best_o_q   <= best_o_d;
    found_q    <= found_d;
    need_q     <= need_d;
    o_q        <= o_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_ord_q  <= res_ord_d;
    out_st_q   <= out_st_d;
    out_addr_q <= out_addr_d;
    out_ord_q  <= out_ord_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign address_o   = out_addr_q;
  assign order_o     = out_ord_q;

endmodule

// ===== tb/bba_alloc_checker.sv =====
`timescale 1ns / 100ps

module bba_alloc_checker import bba_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  bba_cfg_if     cfg_i,
  bba_req_if     req_i,
  bba_rsp_if     rsp_i,
  output int     errors_o,
  output int     pending_o
);

  localparam int unsigned MinOrd   = 4;
  localparam int unsigned MaxOrd   = 16;
  localparam int unsigned HdrBytes = 2;
  localparam int unsigned Granules = 1 << (MaxOrd - MinOrd);

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [AddrW-1:0]  address;
    logic [OrderW-1:0] block_order;
  } alloc_rsp_t;

  logic [OrderW-1:0] pool_reg;
  logic [OrderW-1:0] gran_ord  [Granules];
  bit                gran_free [Granules];
  bit                gran_head [Granules];
  alloc_rsp_t        rsp_fifo[$];

  function automatic int unsigned pool_bits();
    int unsigned p;
    p = pool_reg;
    if (p < 4) p = 5;
    if (p < MinOrd) p = MinOrd;
    if (p > MaxOrd) p = MaxOrd;
    return p;
  endfunction

  task automatic clear_pool();
    for (int i = 0; i < Granules; i++) begin
      gran_ord[i]  = '0;
      gran_free[i] = 0;
      gran_head[i] = 0;
    end
    gran_head[0] = 1;
    gran_free[0] = 1;
    gran_ord[0]  = OrderW'(pool_bits());
  endtask

  task automatic predict_alloc(input logic [SizeW-1:0] sz, output alloc_rsp_t r);
    int unsigned p, total, need, best, best_o, o, g, b;
    bit found;
    p = pool_bits();
    total = 1 << (p - MinOrd);
    need = 0;
    found = 0;
    best = 0;
    best_o = 0;
    r = '0;
    if (sz == 0) begin
      r.status = ST_ZERO;
      return;
    end
    while (need < 40 && (64'd1 << need) < 64'(sz) + HdrBytes) need++;
    if (need < MinOrd) need = MinOrd;
    if (need > p) begin
      r.status = ST_TOO_BIG;
      return;
    end
    g = 0;
    while (g < total) begin
      o = gran_ord[g];
      if (gran_head[g] && gran_free[g] && o >= need && o <= p && (!found || o < best_o)) begin
        found = 1;
        best = g;
        best_o = o;
      end
      if (gran_head[g] && o >= MinOrd && o <= p) g += 1 << (o - MinOrd);
      else g++;
    end
    if (!found) begin
      r.status = ST_NO_FIT;
      return;
    end
    // split down, releasing each upper half
    o = best_o;
    while (o > need) begin
      o--;
      b = best + (1 << (o - MinOrd));
      if (b < Granules) begin
        gran_head[b] = 1;
        gran_free[b] = 1;
        gran_ord[b]  = OrderW'(o);
      end
    end
    gran_ord[best]  = OrderW'(need);
    gran_free[best] = 0;
    r.status      = ST_OK;
    r.address     = AddrW'((best << MinOrd) + HdrBytes);
    r.block_order = OrderW'(need);
  endtask

  task automatic predict_free(input logic [AddrW-1:0] fa, output alloc_rsp_t r);
    int unsigned p, total, off, g, o, b, lo, hi;
    p = pool_bits();
    total = 1 << (p - MinOrd);
    r = '0;
    r.status = ST_IGNORED;
    if (fa < HdrBytes) return;
    off = fa - HdrBytes;
    if (off[MinOrd-1:0] != 0) return;
    off = off >> MinOrd;
    if (off >= total) return;
    g = off;
    if (!gran_head[g] || gran_free[g] || gran_ord[g] < MinOrd || gran_ord[g] > p) return;
    o = gran_ord[g];
    while (o < p) begin
      b = g ^ (1 << (o - MinOrd));
      if (b >= total || !gran_head[b] || !gran_free[b] || gran_ord[b] != o) break;
      lo = (g < b) ? g : b;
      hi = (g < b) ? b : g;
      gran_head[hi] = 0;
      gran_free[hi] = 0;
      gran_ord[hi]  = '0;
      g = lo;
      o++;
      gran_ord[g] = OrderW'(o);
    end
    gran_free[g] = 1;
    r.status      = ST_OK;
    r.address     = AddrW'(g << MinOrd);
    r.block_order = OrderW'(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want, got;
    if (!rst_ni) begin
      pool_reg = OrderW'(16);
      clear_pool();
      rsp_fifo.delete();
      errors_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.status, rsp_i.address, rsp_i.block_order};
        if (rsp_fifo.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = rsp_fifo.pop_front();
          if (want.status != got.status || want.address != got.address ||
              want.block_order != got.block_order) begin
            $display("%0t: mismatch expected status %0d address %h order %0d, actual status %0d address %h order %0d",
                     $time, want.status, want.address, want.block_order,
                     got.status, got.address, got.block_order);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        pool_reg = cfg_i.data;
        clear_pool();
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.action == ACT_FREE) predict_free(req_i.free_address, want);
        else predict_alloc(req_i.request_size, want);
        rsp_fifo.push_back(want);
      end
    end
    pending_o <= rsp_fifo.size();
  end

endmodule

// ===== tb/tb_buddy_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int IdleLimit = 60000;

  logic clk;
  logic rst_n;
  int   errors, pending;
  int   tx_idle, rx_idle;
  int   stall_cnt;
  int   n_alloc_ok, n_free_ok, n_reject, n_cfg;
  logic [AddrW-1:0] live[$];
  logic [AddrW-1:0] last_freed;
  logic             act_fifo[$];

  bba_cfg_if cfg_ch ();
  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  buddy_block_allocator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  bba_alloc_checker u_chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_i     (cfg_ch),
    .req_i     (req_ch),
    .rsp_i     (rsp_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // track live blocks so most frees name a real one
  always @(posedge clk) begin
    logic a;
    if (rst_n && req_ch.valid && req_ch.ready) act_fifo.push_back(req_ch.action);
    if (rst_n && rsp_ch.valid && rsp_ch.ready && act_fifo.size() > 0) begin
      a = act_fifo.pop_front();
      if (rsp_ch.status != ST_OK) n_reject++;
      else if (a == ACT_ALLOC) begin
        n_alloc_ok++;
        live.push_back(rsp_ch.address);
      end else n_free_ok++;
    end
  end

  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= IdleLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("[buddy_block_allocator] ERROR");
      $finish;
    end
  end

  task automatic send(input logic act, input logic [SizeW-1:0] sz, input logic [AddrW-1:0] fa);
    while ($urandom_range(99) < tx_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.request_size <= sz;
    req_ch.free_address <= fa;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || act_fifo.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pool(input logic [OrderW-1:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    live.delete();
    n_cfg++;
  endtask

  task automatic free_live();
    int k;
    k = $urandom_range(live.size() - 1);
    last_freed = live[k];
    live.delete(k);
    send(ACT_FREE, SizeW'($urandom), last_freed);
  endtask

  task automatic random_item(input int p);
    int r, k;
    r = $urandom_range(99);
    if (r < 8) begin
      // noise: null, stray, misaligned or double free
      case ($urandom_range(3))
        0: send(ACT_FREE, SizeW'($urandom), '0);
        1: send(ACT_FREE, SizeW'($urandom), AddrW'($urandom));
        2: send(ACT_FREE, SizeW'($urandom), last_freed);
        default: send(ACT_FREE, SizeW'($urandom), AddrW'($urandom_range(15)));
      endcase
    end else if (r < 12) begin
      send(ACT_ALLOC, SizeW'($urandom), AddrW'($urandom));
    end else if (live.size() > 0 && (r < 50 || live.size() > 30)) begin
      free_live();
    end else begin
      k = $urandom_range((p > 4) ? p - 1 : 4, 1);
      send(ACT_ALLOC, SizeW'($urandom_range((1 << k) - 2, (k > 1) ? (1 << (k - 1)) - 1 : 1)),
           AddrW'($urandom));
    end
  endtask

  initial begin
    logic [OrderW-1:0] pools[8];
    int done;
    pools = '{5'd4, 5'd0, 5'd31, 5'd8, 5'd10, 5'd3, 5'd12, 5'd6};
    n_alloc_ok = 0; n_free_ok = 0; n_reject = 0; n_cfg = 0;
    tx_idle = 0; rx_idle = 0;
    last_freed = '0;
    req_ch.valid = 1'b0; req_ch.action = ACT_ALLOC;
    req_ch.request_size = '0; req_ch.free_address = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, pool of 64 KiB from reset
    send(ACT_ALLOC, 16'd0, 16'd0);
    send(ACT_ALLOC, 16'hFFFF, 16'hFFFF);
    send(ACT_ALLOC, 16'hFFFE, 16'd0);
    send(ACT_ALLOC, 16'd1, 16'd0);
    send(ACT_FREE, 16'd0, 16'd0);
    send(ACT_FREE, 16'd0, 16'd1);
    send(ACT_FREE, 16'd0, 16'd3);
    send(ACT_FREE, 16'd0, 16'hFFFF);
    send(ACT_FREE, 16'd0, 16'd2);
    send(ACT_FREE, 16'd0, 16'd2);
    send(ACT_ALLOC, 16'd14, 16'd0);
    send(ACT_ALLOC, 16'd15, 16'd0);
    send(ACT_ALLOC, 16'd30, 16'd0);
    send(ACT_ALLOC, 16'd1000, 16'd0);
    send(ACT_FREE, 16'd0, 16'd2);
    send(ACT_FREE, 16'd0, 16'd34);
    send(ACT_FREE, 16'd0, 16'd66);
    send(ACT_FREE, 16'd0, 16'd18);
    send(ACT_FREE, 16'd0, 16'd1026);
    send(ACT_FREE, 16'd0, 16'd1026);
    drain();
    live.delete();

    done = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_pool(pools[ph]);
      for (int i = 0; i < 92; i++) begin
        if (done < 250) begin tx_idle = 21; rx_idle = 88; end
        else if (done < 500) begin tx_idle = 88; rx_idle = 21; end
        else begin tx_idle = 0; rx_idle = 0; end
        random_item((pools[ph] < 4) ? 5 : ((pools[ph] > 16) ? 16 : pools[ph]));
        done++;
      end
    end
    // hold off until every result is back, then go on once more
    drain();
    write_pool(5'd16);
    for (int i = 0; i < 20; i++) random_item(16);
    drain();
    repeat (30) @(posedge clk);

    $display("Covered %0d pool settings; %0d allocations and %0d frees succeeded, %0d rejected.",
             n_cfg, n_alloc_ok, n_free_ok, n_reject);
    if (errors == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
